// ===== src/wsg_pkg.sv =====
// Shared types, constants and CORDIC angle table for the waveform sample generator.
// No dependencies; every other file refers to it by scoped names.
package wsg_pkg;

  localparam int unsigned AngleW  = 25;
  localparam int unsigned SampleW = 24;
  localparam int unsigned WordW   = 16;
  localparam int unsigned KindW   = 3;
  localparam int unsigned CfgIdxW = 4;
  localparam int unsigned ThetaW  = 41;  // frequency * angle, Q18.22
  localparam int unsigned FracW   = 22;  // fraction bits of theta
  localparam int unsigned ProdW   = 32;  // amplitude * gain, Q16.16
  localparam int unsigned PhaseW  = 32;  // unsigned fraction of a turn
  localparam int unsigned XyW     = 33;
  localparam int unsigned ZW      = 32;
  localparam int unsigned MaxStages = 24;

  // round(2^32 / (2*pi)), 30 bits
  localparam logic [29:0] InvTwoPi = 30'd683565276;
  // 0.6072529350 in Q30
  localparam logic signed [XyW-1:0] CordicX0 = 33'sd652032874;

  typedef enum logic [KindW-1:0] {
    KIND_SINE   = 3'd0,
    KIND_COSINE = 3'd1,
    KIND_SQUARE = 3'd2,
    KIND_DC     = 3'd3,
    KIND_PULSE  = 3'd4
  } wsg_kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_WAVE_KIND = 4'd0,
    REG_AMPLITUDE = 4'd1,
    REG_FREQUENCY = 4'd2,
    REG_GAIN      = 4'd3
  } wsg_reg_e;

  // How the final sample is formed
  typedef enum logic [1:0] {
    SEL_TRIG = 2'd0,
    SEL_POS  = 2'd1,
    SEL_NEG  = 2'd2,
    SEL_ZERO = 2'd3
  } wsg_sel_e;

  typedef struct packed {
    wsg_sel_e                 sel;
    logic                     want_cos;
    logic                     neg;
    logic signed [ProdW-1:0]  prod;
  } wsg_side_t;

  typedef struct packed {
    logic signed [XyW-1:0] x;
    logic signed [XyW-1:0] y;
    logic signed [ZW-1:0]  z;
  } wsg_rot_t;

  // atan(2^-i) in Q32 turns
  localparam logic signed [ZW-1:0] AtanTurns [MaxStages] = '{
    32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
    32'sd42667331,  32'sd21354465,  32'sd10679838,  32'sd5340245,
    32'sd2670163,   32'sd1335087,   32'sd667544,    32'sd333772,
    32'sd166886,    32'sd83443,     32'sd41722,     32'sd20861,
    32'sd10430,     32'sd5215,      32'sd2608,      32'sd1304,
    32'sd652,       32'sd326,       32'sd163,       32'sd81
  };

endpackage

// ===== src/waveform_sample_generator.sv =====
// Top level of the waveform sample generator: configuration registers,
// front end, CORDIC cell chain and back end. Depends on wsg_pkg and all src modules.
//
//   channel  | handshake              | payload
//   ---------+------------------------+------------------------------------
//   in       | in_valid_i / in_ready_o   | angle_i   (signed Q10.14 radians)
//   out      | out_valid_o / out_ready_i | sample_o  (signed Q16.8, saturated)
//   cfg      | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// One request enters per cycle while the pipeline advances; each passes through the
// front end, one CORDIC cell per stage and the back end.
// The whole pipeline advances as one: it stalls only when the output register
// holds a sample that is not taken, and in_ready_o then drops the same cycle.
// Reset clears all valid bits and loads the register defaults; no clearing pass.
// Configuration writes are always taken (cfg_ready_o is tied high).
module waveform_sample_generator #(
  parameter int unsigned CORDIC_STAGES = 16,
  parameter int unsigned PULSE_PERIOD  = 8,
  parameter int unsigned PULSE_HIGH    = 7
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed [wsg_pkg::AngleW-1:0]    angle_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [wsg_pkg::SampleW-1:0]   sample_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic        [wsg_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic        [wsg_pkg::WordW-1:0]     cfg_data_i
);

  // Configuration registers
  wsg_pkg::wsg_kind_e                 kind_q;
  logic signed [wsg_pkg::WordW-1:0]   amplitude_q;
  logic        [wsg_pkg::WordW-1:0]   frequency_q;
  logic        [wsg_pkg::WordW-1:0]   gain_q;

  assign cfg_ready_o = 1'b1;

  // Register writes; indexes beyond the list drop silently
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q      <= wsg_pkg::KIND_SINE;
      amplitude_q <= 16'sd1280;
      frequency_q <= 16'd2560;
      gain_q      <= 16'd7680;
    end else if (cfg_valid_i) begin
      case (wsg_pkg::wsg_reg_e'(cfg_index_i))
        wsg_pkg::REG_WAVE_KIND:
          kind_q <= wsg_pkg::wsg_kind_e'(cfg_data_i[wsg_pkg::KindW-1:0]);
        wsg_pkg::REG_AMPLITUDE: amplitude_q <= $signed(cfg_data_i);
        wsg_pkg::REG_FREQUENCY: frequency_q <= cfg_data_i;
        wsg_pkg::REG_GAIN:      gain_q      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Global advance: hold everything while a finished sample waits
  logic advance;
  assign advance    = !out_valid_o || out_ready_i;
  assign in_ready_o = advance;

  // Chain links: index 0 is the front end output, index k the output of cell k-1
  logic               chain_valid [CORDIC_STAGES+1];
  wsg_pkg::wsg_rot_t  chain_rot   [CORDIC_STAGES+1];
  wsg_pkg::wsg_side_t chain_side  [CORDIC_STAGES+1];

  wsg_front #(
    .PULSE_PERIOD (PULSE_PERIOD),
    .PULSE_HIGH   (PULSE_HIGH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (advance),
    .valid_i     (in_valid_i),
    .angle_i     (angle_i),
    .kind_i      (kind_q),
    .amplitude_i (amplitude_q),
    .frequency_i (frequency_q),
    .gain_i      (gain_q),
    .valid_o     (chain_valid[0]),
    .rot_o       (chain_rot[0]),
    .side_o      (chain_side[0])
  );

  // One micro-rotation per cell; each hands x, y, z and side data onward whenever the pipeline advances
  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
    wsg_cordic_cell #(
      .STAGE (g)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (advance),
      .valid_i (chain_valid[g]),
      .rot_i   (chain_rot[g]),
      .side_i  (chain_side[g]),
      .valid_o (chain_valid[g+1]),
      .rot_o   (chain_rot[g+1]),
      .side_o  (chain_side[g+1])
    );
  end

  wsg_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (advance),
    .valid_i  (chain_valid[CORDIC_STAGES]),
    .rot_i    (chain_rot[CORDIC_STAGES]),
    .side_i   (chain_side[CORDIC_STAGES]),
    .valid_o  (out_valid_o),
    .sample_o (sample_o)
  );

endmodule

// ===== src/wsg_front.sv =====
// Front end: angle and scale products, phase reduction, quadrant fold and
// square/pulse decision. Depends on wsg_pkg.
module wsg_front #(
  parameter int unsigned PULSE_PERIOD = 8,
  parameter int unsigned PULSE_HIGH   = 7
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  en_i,
  input  logic                                  valid_i,
  input  logic signed [wsg_pkg::AngleW-1:0]     angle_i,
  input  wsg_pkg::wsg_kind_e                    kind_i,
  input  logic signed [wsg_pkg::WordW-1:0]      amplitude_i,
  input  logic        [wsg_pkg::WordW-1:0]      frequency_i,
  input  logic        [wsg_pkg::WordW-1:0]      gain_i,
  output logic                                  valid_o,
  output wsg_pkg::wsg_rot_t                     rot_o,
  output wsg_pkg::wsg_side_t                    side_o
);

  localparam int unsigned ThetaW = wsg_pkg::ThetaW;
  localparam int unsigned ProdW  = wsg_pkg::ProdW;
  localparam int unsigned NW     = ThetaW - wsg_pkg::FracW;
  localparam int unsigned LoW    = 24;
  localparam int unsigned HiW    = ThetaW - LoW;
  localparam int unsigned PloW   = LoW + 30;
  localparam int unsigned PhiW   = HiW + 30;
  localparam int unsigned RecipShift = NW + 5;
  localparam int unsigned RecipW     = RecipShift;
  localparam logic [RecipW-1:0] Recip =
    RecipW'(((64'd1 << RecipShift) + 64'(PULSE_PERIOD) - 64'd1) / 64'(PULSE_PERIOD));
  localparam int unsigned NmW = NW + RecipW;
  localparam logic signed [wsg_pkg::ZW:0] QuarterTurn = 33'sd1073741824;
  localparam logic signed [wsg_pkg::ZW:0] HalfTurn    = 33'sd2147483648;

  // stage 1
  logic                     v1_q, v2_q, v3_q, v4_q;
  logic signed [ThetaW:0]   theta_full;
  logic signed [ProdW:0]    prod_full;
  logic signed [ThetaW-1:0] theta1_q;
  logic signed [ProdW-1:0]  prod1_q, prod2_q, prod3_q;
  wsg_pkg::wsg_kind_e       kind1_q, kind2_q, kind3_q;

  assign theta_full = (ThetaW+1)'($signed({1'b0, frequency_i})) * (ThetaW+1)'(angle_i);
  assign prod_full  = (ProdW+1)'(amplitude_i) * (ProdW+1)'($signed({1'b0, gain_i}));

  // stage 2
  logic        [LoW-1:0]    theta_lo;
  logic signed [HiW-1:0]    theta_hi;
  logic        [ThetaW-1:0] theta_abs;
  logic        [PloW-1:0]   plo_q;
  logic signed [PhiW-1:0]   phi_q;
  logic        [NW-1:0]     n2_q, n3_q;
  logic                     pos2_q, neg2_q, pos3_q, neg3_q;

  assign theta_lo  = theta1_q[LoW-1:0];
  assign theta_hi  = $signed(theta1_q[ThetaW-1:LoW]);
  assign theta_abs = theta1_q[ThetaW-1] ? ThetaW'(-theta1_q) : ThetaW'(theta1_q);

  // stage 3
  logic [PloW-1:0]             phase_sum;
  logic [wsg_pkg::PhaseW-1:0]  phase3_q;
  logic [NmW-1:0]              nm_q;

  assign phase_sum = plo_q + {phi_q[PloW-LoW-1:0], {LoW{1'b0}}};

  // stage 4
  logic [NW-1:0]                  quot;
  logic [NW-1:0]                  rem_raw, rem_fix;
  logic                           pulse_on;
  logic signed [wsg_pkg::ZW:0]    z_raw, z_fold;
  logic                           fold_neg;
  wsg_pkg::wsg_side_t             side_d;

  assign quot     = nm_q[NmW-1:RecipShift];
  assign rem_raw  = n3_q - NW'(quot * PULSE_PERIOD);
  assign rem_fix  = (rem_raw >= NW'(PULSE_PERIOD)) ? rem_raw - NW'(PULSE_PERIOD) : rem_raw;
  assign pulse_on = rem_fix < NW'(PULSE_HIGH);

  always_comb begin
    z_raw    = (wsg_pkg::ZW+1)'($signed(phase3_q));
    z_fold   = z_raw;
    fold_neg = 1'b0;
    if (z_raw > QuarterTurn) begin
      z_fold   = z_raw - HalfTurn;
      fold_neg = 1'b1;
    end else if (z_raw < -QuarterTurn) begin
      z_fold   = z_raw + HalfTurn;
      fold_neg = 1'b1;
    end
  end

  always_comb begin
    side_d.prod     = prod3_q;
    side_d.neg      = fold_neg;
    side_d.want_cos = 1'b0;
    side_d.sel      = wsg_pkg::SEL_ZERO;
    case (kind3_q)
      wsg_pkg::KIND_SINE: side_d.sel = wsg_pkg::SEL_TRIG;
      wsg_pkg::KIND_COSINE: begin
        side_d.sel      = wsg_pkg::SEL_TRIG;
        side_d.want_cos = 1'b1;
      end
      wsg_pkg::KIND_SQUARE:
        side_d.sel = (pos3_q && n3_q[0]) ? wsg_pkg::SEL_POS : wsg_pkg::SEL_NEG;
      wsg_pkg::KIND_DC: side_d.sel = wsg_pkg::SEL_POS;
      wsg_pkg::KIND_PULSE:
        side_d.sel = (neg3_q || pulse_on) ? wsg_pkg::SEL_POS : wsg_pkg::SEL_ZERO;
      default: side_d.sel = wsg_pkg::SEL_ZERO;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      theta1_q <= $signed(theta_full[ThetaW-1:0]);
      prod1_q  <= $signed(prod_full[ProdW-1:0]);
      kind1_q  <= kind_i;

      plo_q    <= PloW'(theta_lo) * PloW'(wsg_pkg::InvTwoPi);
      phi_q    <= PhiW'(theta_hi) * PhiW'($signed({1'b0, wsg_pkg::InvTwoPi}));
      n2_q     <= theta_abs[ThetaW-1:wsg_pkg::FracW];
      pos2_q   <= !theta1_q[ThetaW-1] && (theta1_q != '0);
      neg2_q   <= theta1_q[ThetaW-1];
      prod2_q  <= prod1_q;
      kind2_q  <= kind1_q;

      phase3_q <= phase_sum[PloW-1:wsg_pkg::FracW];
      nm_q     <= NmW'(n2_q) * NmW'(Recip);
      n3_q     <= n2_q;
      pos3_q   <= pos2_q;
      neg3_q   <= neg2_q;
      prod3_q  <= prod2_q;
      kind3_q  <= kind2_q;

      rot_o.x  <= wsg_pkg::CordicX0;
      rot_o.y  <= '0;
      rot_o.z  <= $signed(z_fold[wsg_pkg::ZW-1:0]);
      side_o   <= side_d;
    end
  end

  assign valid_o = v4_q;

endmodule

// ===== src/wsg_cordic_cell.sv =====
// One rotation-mode CORDIC micro-rotation, registered, with side data in tow.
// Depends on wsg_pkg.
module wsg_cordic_cell #(
  parameter int unsigned STAGE = 0
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  wsg_pkg::wsg_rot_t  rot_i,
  input  wsg_pkg::wsg_side_t side_i,
  output logic               valid_o,
  output wsg_pkg::wsg_rot_t  rot_o,
  output wsg_pkg::wsg_side_t side_o
);

  logic signed [wsg_pkg::XyW-1:0] dx, dy;
  logic signed [wsg_pkg::ZW-1:0]  atan_c;
  wsg_pkg::wsg_rot_t              rot_d;
  logic                           valid_q;

  assign dx     = $signed(rot_i.y) >>> STAGE;
  assign dy     = $signed(rot_i.x) >>> STAGE;
  assign atan_c = wsg_pkg::AtanTurns[STAGE];

  always_comb begin
    if (!rot_i.z[wsg_pkg::ZW-1]) begin
      rot_d.x = rot_i.x - dx;
      rot_d.y = rot_i.y + dy;
      rot_d.z = rot_i.z - atan_c;
    end else begin
      rot_d.x = rot_i.x + dx;
      rot_d.y = rot_i.y - dy;
      rot_d.z = rot_i.z + atan_c;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rot_o  <= rot_d;
      side_o <= side_i;
    end
  end

  assign valid_o = valid_q;

endmodule

// ===== src/wsg_back.sv =====
// Back end: pick sine or cosine, scale by amplitude times gain, select the
// waveform value and saturate into the output register. Depends on wsg_pkg.
module wsg_back (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic                                valid_i,
  input  wsg_pkg::wsg_rot_t                   rot_i,
  input  wsg_pkg::wsg_side_t                  side_i,
  output logic                                valid_o,
  output logic signed [wsg_pkg::SampleW-1:0]  sample_o
);

  localparam int unsigned XyW   = wsg_pkg::XyW;
  localparam int unsigned ProdW = wsg_pkg::ProdW;
  localparam int unsigned MulW  = ProdW + XyW;
  localparam int unsigned SW    = MulW - 38 + 1;
  localparam logic signed [SW-1:0] SatMax = SW'(24'sh7FFFFF);
  localparam logic signed [SW-1:0] SatMin = -SatMax - SW'(1);

  logic                     v1_q, v2_q, v3_q;
  logic signed [XyW-1:0]    w_sel, w_d, w1_q;
  wsg_pkg::wsg_sel_e        sel1_q, sel2_q;
  logic signed [ProdW-1:0]  prod1_q, prod2_q;
  logic signed [MulW-1:0]   mul_q;
  logic signed [ProdW:0]    prod_neg;
  logic signed [SW-1:0]     s_d;
  logic signed [wsg_pkg::SampleW-1:0] sample_q;

  assign w_sel = side_i.want_cos ? rot_i.x : rot_i.y;
  assign w_d   = side_i.neg ? -w_sel : w_sel;

  assign prod_neg = -((ProdW+1)'(prod2_q));

  always_comb begin
    case (sel2_q)
      wsg_pkg::SEL_TRIG: s_d = SW'($signed(mul_q[MulW-1:38]));
      wsg_pkg::SEL_POS:  s_d = SW'($signed(prod2_q[ProdW-1:8]));
      wsg_pkg::SEL_NEG:  s_d = SW'($signed(prod_neg[ProdW:8]));
      default:           s_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      w1_q    <= w_d;
      sel1_q  <= side_i.sel;
      prod1_q <= side_i.prod;

      mul_q   <= MulW'(prod1_q) * MulW'(w1_q);
      sel2_q  <= sel1_q;
      prod2_q <= prod1_q;

      if (s_d > SatMax) begin
        sample_q <= wsg_pkg::SampleW'(SatMax);
      end else if (s_d < SatMin) begin
        sample_q <= wsg_pkg::SampleW'(SatMin);
      end else begin
        sample_q <= wsg_pkg::SampleW'(s_d);
      end
    end
  end

  assign valid_o  = v3_q;
  assign sample_o = sample_q;

endmodule
